>>> hdl/lbps_pkg.sv
// ----------------------------------------------------------------------------
// Indicator blink pattern sequencer package
// Shared word types, pattern codes, register map and the pattern table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbps_pkg;

  // Input word: a tick or a pattern start.
  typedef struct packed {
    logic       func;
    logic [2:0] op_code;
  } in_t;

  // Result word: light levels and status after one input word.
  typedef struct packed {
    logic flash_on;
    logic laser_on;
    logic busy_res;
    logic soft_reset;
  } out_t;

  // Period registers as seen by the sequencer core.
  typedef struct packed {
    logic [15:0] fast_period;
    logic [15:0] slow_period;
  } cfg_t;

  // One pattern's description.
  typedef struct packed {
    logic [3:0] limit;
    logic       laser;
    logic       slow;
  } pattern_t;

  // Input function codes.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // Pattern codes.
  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_ERASE     = 3'd1;
  localparam logic [2:0] MODE_PAIRED    = 3'd2;
  localparam logic [2:0] MODE_CONNECTED = 3'd3;
  localparam logic [2:0] MODE_LASER_ON  = 3'd4;
  localparam logic [2:0] MODE_LASER_OFF = 3'd5;

  // Register map: index of each register, selected by the word address.
  localparam logic REG_FAST_PERIOD = 1'b0;
  localparam logic REG_SLOW_PERIOD = 1'b1;

  // Register reset values.
  localparam logic [15:0] FAST_PERIOD_RST = 16'h40FF;
  localparam logic [15:0] SLOW_PERIOD_RST = 16'hBFFF;

  // Paired pattern runs slow until this step.
  localparam logic [3:0] PAIRED_FAST_STEP = 4'd2;

  // Pattern table.
  function automatic pattern_t pattern_lookup(input logic [2:0] mode);
    pattern_t p;
    begin
      p = '{limit: 4'd0, laser: 1'b0, slow: 1'b0};
      case (mode)
        MODE_ERASE:     p = '{limit: 4'd10, laser: 1'b0, slow: 1'b0};
        MODE_PAIRED:    p = '{limit: 4'd8,  laser: 1'b0, slow: 1'b0};
        MODE_CONNECTED: p = '{limit: 4'd6,  laser: 1'b0, slow: 1'b0};
        MODE_LASER_ON:  p = '{limit: 4'd4,  laser: 1'b1, slow: 1'b1};
        MODE_LASER_OFF: p = '{limit: 4'd6,  laser: 1'b1, slow: 1'b0};
        default:        p = '{limit: 4'd0,  laser: 1'b0, slow: 1'b0};
      endcase
      return p;
    end
  endfunction

endpackage

>>> hdl/lbps_core.sv
// ----------------------------------------------------------------------------
// Indicator blink pattern sequencer core
// Holds the pattern state and works out each input word combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbps_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  lbps_pkg::in_t  item,
  input  lbps_pkg::cfg_t cfg,
  output lbps_pkg::out_t res
);

  logic [2:0]  mode_r,  mode_nxt;
  logic [3:0]  step_r,  step_nxt;
  logic [15:0] tick_r,  tick_nxt;
  logic        flash_r, flash_nxt;
  logic        laser_r, laser_nxt;
  logic        pulse;

  lbps_pkg::pattern_t pat;
  logic        running;
  logic        first;
  logic [15:0] tick_inc;
  logic        over_fast;
  logic        over_slow;
  logic        exceed;
  logic        light_nxt;
  logic        light_set;
  logic [3:0]  step_base;

  // Per-item decode of the pattern and the tick arithmetic.
  always_comb begin
    pat       = lbps_pkg::pattern_lookup(mode_r);
    running   = (mode_r != lbps_pkg::MODE_NONE) && (mode_r <= lbps_pkg::MODE_LASER_OFF);
    first     = (step_r == 4'd0);
    tick_inc  = (first ? 16'd0 : tick_r) + 16'd1;
    over_fast = tick_inc > cfg.fast_period;
    over_slow = tick_inc > cfg.slow_period;
    if (mode_r == lbps_pkg::MODE_PAIRED) begin
      exceed = ((step_r >= lbps_pkg::PAIRED_FAST_STEP) && over_fast) || over_slow;
    end else if (pat.slow) begin
      exceed = over_slow;
    end else begin
      exceed = over_fast;
    end
    step_base = first ? 4'd1 : step_r;
  end

  // Next state for the accepted word.
  always_comb begin
    mode_nxt  = mode_r;
    step_nxt  = step_r;
    tick_nxt  = tick_r;
    flash_nxt = flash_r;
    laser_nxt = laser_r;
    pulse     = 1'b0;
    light_set = 1'b0;
    light_nxt = 1'b0;
    if (item.func == lbps_pkg::FUNC_START) begin
      // Start or cancel; unused codes are ignored.
      if (item.op_code <= lbps_pkg::MODE_LASER_OFF) begin
        mode_nxt = item.op_code;
        step_nxt = 4'd0;
      end
    end else if (running) begin
      if (step_r >= pat.limit) begin
        // Pattern finished: light off, erase asks for a soft reset.
        light_set = 1'b1;
        light_nxt = 1'b0;
        mode_nxt  = lbps_pkg::MODE_NONE;
        step_nxt  = 4'd0;
        pulse     = (mode_r == lbps_pkg::MODE_ERASE);
      end else begin
        // The first tick turns the light on; a step toggles it by parity.
        light_set = first | exceed;
        light_nxt = exceed ? ~step_r[0] : 1'b1;
        tick_nxt  = exceed ? 16'd0 : tick_inc;
        step_nxt  = exceed ? step_base + 4'd1 : step_base;
      end
    end
    if (light_set) begin
      if (pat.laser) begin
        laser_nxt = light_nxt;
      end else begin
        flash_nxt = light_nxt;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lbps_pkg::MODE_NONE;
      step_r  <= 4'd0;
      tick_r  <= 16'd0;
      flash_r <= 1'b0;
      laser_r <= 1'b0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      step_r  <= step_nxt;
      tick_r  <= tick_nxt;
      flash_r <= flash_nxt;
      laser_r <= laser_nxt;
    end
  end

  // Result word for this item.
  assign res.flash_on   = flash_nxt;
  assign res.laser_on   = laser_nxt;
  assign res.busy_res   = (mode_nxt != lbps_pkg::MODE_NONE);
  assign res.soft_reset = pulse;

endmodule

>>> hdl/led_laser_blink_pattern_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Indicator blink pattern sequencer
// Runs flashlight and laser blink patterns, one result word per input word.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                   Direction  Word
//  input    in_valid, in_ready, in_data             in         func, op_code
//  result   out_valid, out_ready, out_data          out        lights, busy, reset
//  config   cfg_psel .. cfg_prdata, cfg_pready      in/out     two 16-bit periods
//
// Each word is captured in an input register, processed by the core and held
// in the result register; one word per cycle is sustained while out_ready is
// held high. The input register keeps taking words while a result waits,
// and stalls only when both registers are full. Reset is synchronous and
// returns all pattern state and the periods to their defaults.
`timescale 1ns / 1ps

module led_laser_blink_pattern_sequencer_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lbps_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lbps_pkg::out_t  out_data,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [2:0]      cfg_paddr,
  input  logic [31:0]     cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);

  logic           hold_valid_r;
  lbps_pkg::in_t  hold_data_r;
  logic           out_valid_r;
  lbps_pkg::out_t out_data_r;
  lbps_pkg::cfg_t cfg_r;
  lbps_pkg::out_t res;
  logic           out_free;
  logic           advance;
  logic           cfg_wr;

  // Configuration registers, decoded on the word address bit.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_period <= lbps_pkg::FAST_PERIOD_RST;
      cfg_r.slow_period <= lbps_pkg::SLOW_PERIOD_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == lbps_pkg::REG_SLOW_PERIOD) begin
        cfg_r.slow_period <= cfg_pwdata[15:0];
      end else begin
        cfg_r.fast_period <= cfg_pwdata[15:0];
      end
    end
  end

  // Read back, the low address bits are ignored.
  always_comb begin
    if (cfg_paddr[2] == lbps_pkg::REG_SLOW_PERIOD) begin
      cfg_prdata = {16'd0, cfg_r.slow_period};
    end else begin
      cfg_prdata = {16'd0, cfg_r.fast_period};
    end
  end

  // Handshake between the input register and the result register.
  assign out_free = !out_valid_r || out_ready;
  assign advance  = hold_valid_r && out_free;
  assign in_ready = !hold_valid_r || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_data_r <= in_data;
    end
  end

  // Pattern state and per-word processing.
  lbps_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (hold_data_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= hold_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
